@@ src/ucs_pkg.sv @@
// ----------------------------------------------------------------------------
// ucs_pkg
// shared types and constants for the utf-8 to ucs-2 decoder
// ----------------------------------------------------------------------------
package ucs_pkg;

    localparam int UCS_FIFO_DEPTH = 4;
    localparam logic [15:0] UCS_MAX_CHARS_RST = 16'hFFFF;

    // register byte addresses
    localparam logic [2:0] UCS_ADDR_MAX_CHARS = 3'd0;

    // continuation bytes still expected
    typedef enum logic [1:0] {
        PEND_NONE = 2'd0,
        PEND_ONE  = 2'd1,
        PEND_TWO  = 2'd2
    } t_ucs_pend;

    // one result word
    typedef struct packed {
        logic        term_stored;
        logic [15:0] unit_count;
        logic        is_end;
        logic [15:0] code_unit;
    } t_ucs_item;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_ucs_qstat;

endpackage

@@ src/ucs_front.sv @@
// ----------------------------------------------------------------------------
// ucs_front
// accepts bytes, tracks the character in flight and the unit count
// ----------------------------------------------------------------------------
module ucs_front
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_max_chars,
    output logic        o_push,
    output t_ucs_item   o_item
);

    t_ucs_pend   r_pend, n_pend;
    logic [9:0]  r_partial, n_partial;
    logic [15:0] r_count, n_count;
    logic [15:0] w_count_inc;

    assign w_count_inc = r_count + 16'd1;

    always_comb begin
        n_pend    = r_pend;
        n_partial = r_partial;
        n_count   = r_count;
        o_push    = 1'b0;
        o_item    = '0;
        if (i_accept) begin
            if (i_byte == 8'h00) begin
                // end of string, any partial character is dropped
                o_push             = 1'b1;
                o_item.is_end      = 1'b1;
                o_item.unit_count  = r_count;
                o_item.term_stored = (r_count < i_max_chars);
                n_pend             = PEND_NONE;
                n_partial          = '0;
                n_count            = '0;
            end else if (r_pend == PEND_TWO) begin
                n_partial = {r_partial[3:0], i_byte[5:0]};
                n_pend    = PEND_ONE;
            end else if (r_pend == PEND_ONE) begin
                o_push            = 1'b1;
                o_item.code_unit  = {r_partial, i_byte[5:0]};
                o_item.unit_count = w_count_inc;
                n_count           = w_count_inc;
                n_pend            = PEND_NONE;
                n_partial         = '0;
            end else if (r_count >= i_max_chars) begin
                // limit reached, lead byte ignored
            end else if (!i_byte[7]) begin
                o_push            = 1'b1;
                o_item.code_unit  = {9'd0, i_byte[6:0]};
                o_item.unit_count = w_count_inc;
                n_count           = w_count_inc;
            end else if (i_byte[7:5] == 3'b110) begin
                n_partial = {5'd0, i_byte[4:0]};
                n_pend    = PEND_ONE;
            end else if (i_byte[7:4] == 4'hE) begin
                n_partial = {6'd0, i_byte[3:0]};
                n_pend    = PEND_TWO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= PEND_NONE;
            r_partial <= '0;
            r_count   <= '0;
        end else begin
            r_pend    <= n_pend;
            r_partial <= n_partial;
            r_count   <= n_count;
        end
    end

endmodule

@@ src/ucs_fifo.sv @@
// ----------------------------------------------------------------------------
// ucs_fifo
// short result queue between front and back
// ----------------------------------------------------------------------------
module ucs_fifo
    import ucs_pkg::*;
#(
    parameter int DEPTH = UCS_FIFO_DEPTH
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_ucs_item  i_item,
    input  logic       i_pop,
    output t_ucs_item  o_item,
    output t_ucs_qstat o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_ucs_item         r_mem [DEPTH];
    logic [AW-1:0]     r_wr, n_wr;
    logic [AW-1:0]     r_rd, n_rd;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;
    assign o_item = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + AW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + AW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ src/ucs_back.sv @@
// ----------------------------------------------------------------------------
// ucs_back
// output register stage, drains the queue into the master stream
// ----------------------------------------------------------------------------
module ucs_back
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ucs_qstat  i_stat,
    input  t_ucs_item   i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data,
    output logic        o_last,
    output logic        o_user
);

    logic      r_valid, n_valid;
    t_ucs_item r_item;

    assign o_pop   = !i_stat.empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);

    assign o_valid = r_valid;
    assign o_data  = {r_item.unit_count, r_item.code_unit};
    assign o_last  = r_item.is_end;
    assign o_user  = r_item.term_stored;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

@@ src/utf8_to_ucs2_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder
// utf-8 byte stream in, ucs-2 code units and end-of-string count out
// ----------------------------------------------------------------------------
// an accepted byte's result word passes through the queue and then the output register
// throughput: one byte per cycle while the queue is not full, set by the front decode
// a queue of FIFO_DEPTH words lets the output stall without stopping input
// until the queue fills
// reset (synchronous, active low): decode state and count cleared, queue
// and output emptied, max_chars back to 65535
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder
    import ucs_pkg::*;
#(
    parameter int FIFO_DEPTH = UCS_FIFO_DEPTH
)(
    input  logic        i_clk,
    input  logic        i_rst_n,

    // byte input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte

    // code unit output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic        m_axis_tlast,   // is_end
    output logic        m_axis_tuser,   // terminator_stored

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_max_chars;
    logic        w_accept;
    logic        w_push;
    logic        w_pop;
    t_ucs_item   w_front_item;
    t_ucs_item   w_queue_item;
    t_ucs_qstat  w_qstat;

    // register port, single register, always ready
    assign pready = 1'b1;
    assign prdata = (paddr == UCS_ADDR_MAX_CHARS) ? {16'd0, r_max_chars} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= UCS_MAX_CHARS_RST;
        end else if (psel && penable && pwrite && paddr == UCS_ADDR_MAX_CHARS) begin
            r_max_chars <= pwdata[15:0];
        end
    end

    // input is taken whenever the queue has room for a possible result
    assign s_axis_tready = !w_qstat.full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // front: decode and count
    ucs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (s_axis_tdata),
        .i_max_chars (r_max_chars),
        .o_push      (w_push),
        .o_item      (w_front_item)
    );

    // queue between decode and output
    ucs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_qstat)
    );

    // back: output register
    ucs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_qstat),
        .i_item  (w_queue_item),
        .o_pop   (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast),
        .o_user  (m_axis_tuser)
    );

endmodule

@@ bench/utf8_to_ucs2_decoder_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_check
// watches the byte input, the result output and the register port, decodes
// every accepted byte on its own and compares each result word in order
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_check
    import ucs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [15:0] code_unit, [31:16] unit_count
    input  logic        m_axis_tlast,   // is_end
    input  logic        m_axis_tuser,   // terminator_stored

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    output int          o_fail_count,
    output int          o_pending
);

    // decoder state as the block should hold it
    t_ucs_pend   cont_left   = PEND_NONE;
    logic [9:0]  char_bits   = '0;
    logic [15:0] units_held  = '0;
    logic [15:0] unit_limit  = UCS_MAX_CHARS_RST;

    t_ucs_item   expected_units[$];
    int          mismatches  = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // one byte through the decoder, returns 1 when it yields a word
    function automatic bit decode_utf8_byte(input logic [7:0] b, output t_ucs_item word);
        word = '0;
        if (b == 8'h00) begin
            // end of string, any half-built character is dropped
            word.is_end      = 1'b1;
            word.unit_count  = units_held;
            word.term_stored = (units_held < unit_limit);
            cont_left  = PEND_NONE;
            char_bits  = '0;
            units_held = '0;
            return 1'b1;
        end
        if (cont_left == PEND_TWO) begin
            char_bits = {char_bits[3:0], b[5:0]};
            cont_left = PEND_ONE;
            return 1'b0;
        end
        if (cont_left == PEND_ONE) begin
            // a started character completes even past the limit
            word.code_unit  = {char_bits, b[5:0]};
            cont_left  = PEND_NONE;
            char_bits  = '0;
            units_held = units_held + 16'd1;
            word.unit_count = units_held;
            return 1'b1;
        end
        if (units_held >= unit_limit)
            return 1'b0;
        if (!b[7]) begin
            word.code_unit  = {9'd0, b[6:0]};
            units_held = units_held + 16'd1;
            word.unit_count = units_held;
            return 1'b1;
        end
        if (b[7:5] == 3'b110) begin
            char_bits = {5'd0, b[4:0]};
            cont_left = PEND_ONE;
        end else if (b[7:4] == 4'hE) begin
            char_bits = {6'd0, b[3:0]};
            cont_left = PEND_TWO;
        end
        // stray continuation and 1111 leads fall through with no word
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_ucs_item want;
        t_ucs_item seen;
        t_ucs_item made;
        if (!i_rst_n) begin
            cont_left  = PEND_NONE;
            char_bits  = '0;
            units_held = '0;
            unit_limit = UCS_MAX_CHARS_RST;
            expected_units.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.code_unit   = m_axis_tdata[15:0];
                seen.unit_count  = m_axis_tdata[31:16];
                seen.is_end      = m_axis_tlast;
                seen.term_stored = m_axis_tuser;
                if (expected_units.size() == 0) begin
                    mismatches++;
                    $display("%0t unexpected word: unit %h count %0d end %b term %b",
                             $time, seen.code_unit, seen.unit_count, seen.is_end,
                             seen.term_stored);
                end else begin
                    want = expected_units.pop_front();
                    if (seen !== want) begin
                        mismatches++;
                        $display("%0t word mismatch: expected unit %h count %0d end %b term %b",
                                 $time, want.code_unit, want.unit_count, want.is_end,
                                 want.term_stored);
                        $display("%0t                  actual unit %h count %0d end %b term %b",
                                 $time, seen.code_unit, seen.unit_count, seen.is_end,
                                 seen.term_stored);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                if (decode_utf8_byte(s_axis_tdata, made))
                    expected_units.push_back(made);
            if (psel && penable && pready && paddr == UCS_ADDR_MAX_CHARS) begin
                if (pwrite) begin
                    unit_limit = pwdata[15:0];
                end else if (prdata !== {16'd0, unit_limit}) begin
                    mismatches++;
                    $display("%0t max_chars read: expected %h actual %h",
                             $time, {16'd0, unit_limit}, prdata);
                end
            end
        end
        o_pending    <= expected_units.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ bench/utf8_to_ucs2_decoder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_ucs2_decoder_test
// drives utf-8 strings into the decoder under several max_chars settings,
// with random gaps on the input and stalls on the output; a checker beside
// the block predicts every word and reports mismatches
// ----------------------------------------------------------------------------
module utf8_to_ucs2_decoder_test;
    import ucs_pkg::*;

    // unmapped slot at address 4, writes there must be dropped
    localparam logic [2:0] SPARE_ADDR = 3'd4;

    // covers the output queue and output register of a busy pipe
    localparam int SETTLE_CYCLES = 8;
    // long enough for the output queue and the pipe to fill
    localparam int LONG_HOLD     = 80;

    // receiver stall patterns
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;       // [7:0] in_byte

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;             // [15:0] code_unit, [31:16] unit_count
    logic        m_axis_tlast;             // is_end
    logic        m_axis_tuser;             // terminator_stored

    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          words_pending;

    // sender pacing
    int          burst_left    = 0;
    int          gap_max       = 0;
    logic [7:0]  utf8_text[$];

    // receiver control
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;
    int          rx_left       = 0;
    int          rx_tick       = 0;
    t_rx_mode    rx_mode       = RX_ALWAYS;

    always #1 i_clk = ~i_clk;

    utf8_to_ucs2_decoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    utf8_to_ucs2_decoder_check u_unit_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (words_pending)
    );

    // receiver: a long hold on request, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_left = $urandom_range(20, 200);
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            end
            rx_left--;
            case (rx_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) < 4);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    // one byte on the input, bursts broken by random gaps
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_text();
        while (utf8_text.size() > 0)
            send_byte(utf8_text.pop_front());
        s_axis_tvalid <= 1'b0;
    endtask

    // wait for every predicted word, then let the pipe settle
    task automatic wait_drained();
        do @(posedge i_clk); while (words_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read data is compared by the checker
    task automatic reg_read(input logic [2:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // continuation byte, mostly well formed, sometimes any nonzero value
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 4) != 0)
            return 8'h80 | 8'($urandom_range(0, 63));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void add_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            utf8_text.push_back(8'($urandom_range(1, 127)));
        end else if (pick < 68) begin
            utf8_text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            utf8_text.push_back(cont_byte());
        end else if (pick < 88) begin
            utf8_text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            utf8_text.push_back(cont_byte());
            utf8_text.push_back(cont_byte());
        end else if (pick < 94) begin
            // stray continuation as a lead
            utf8_text.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end else begin
            // four-byte and longer leads are not handled
            utf8_text.push_back(8'($urandom_range(8'hF0, 8'hFF)));
        end
    endfunction

    // one zero-terminated string, sometimes cut inside a character or pure noise
    function automatic void add_random_string();
        int len;
        int cut;
        len = $urandom_range(0, 10);
        if ($urandom_range(0, 19) == 0) begin
            repeat (len) utf8_text.push_back(8'($urandom_range(1, 255)));
        end else begin
            repeat (len) add_char();
            cut = $urandom_range(0, 9);
            if (cut == 0) begin
                utf8_text.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            end else if (cut == 1) begin
                utf8_text.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                if ($urandom_range(0, 1))
                    utf8_text.push_back(cont_byte());
            end
        end
        utf8_text.push_back(8'h00);
    endfunction

    // new limit (upper data bits random, they must be ignored), then strings
    task automatic run_random_phase(input int n_bytes, input logic [15:0] limit,
                                    input int idle_max);
        logic [31:0] word;
        wait_drained();
        word       = $urandom;
        word[15:0] = limit;
        reg_write(UCS_ADDR_MAX_CHARS, word);
        reg_read(UCS_ADDR_MAX_CHARS);
        gap_max = idle_max;
        while (utf8_text.size() < n_bytes)
            add_random_string();
        send_text();
    endtask

    initial begin
        #200_000;
        $display("[utf8_to_ucs2_decoder] ERROR");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the limit
        reg_read(UCS_ADDR_MAX_CHARS);

        // directed: empty string, ascii extremes, two- and three-byte forms,
        // continuation top bits ignored, illegal leads, cut characters
        gap_max   = 3;
        utf8_text = '{8'h00,
                      8'h41, 8'h7F, 8'h01, 8'h00,
                      8'hC2, 8'hA9, 8'hDF, 8'hBF,
                      8'hE2, 8'h82, 8'hAC, 8'hEF, 8'hBF, 8'hBF,
                      8'hE0, 8'hFF, 8'h01,
                      8'h80, 8'hBF, 8'hF0, 8'hFF,
                      8'hE4, 8'h00,
                      8'hC3, 8'h00,
                      8'hE4, 8'hB8, 8'h00};
        send_text();

        // zero limit: every character ignored, end word still comes
        wait_drained();
        reg_write(UCS_ADDR_MAX_CHARS, 32'h0000_0000);
        utf8_text = '{8'h41, 8'hC2, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'h00, 8'h00};
        send_text();

        // the unmapped slot must not touch max_chars
        wait_drained();
        reg_write(SPARE_ADDR, 32'h0000_0003);
        reg_read(UCS_ADDR_MAX_CHARS);

        // limit lowered while a three-byte character is half in
        reg_write(UCS_ADDR_MAX_CHARS, 32'h0000_FFFF);
        utf8_text = '{8'h41, 8'h42, 8'hE2};
        send_text();
        wait_drained();
        reg_write(UCS_ADDR_MAX_CHARS, 32'h0000_0001);
        reg_read(UCS_ADDR_MAX_CHARS);
        utf8_text = '{8'h82, 8'hAC, 8'h43, 8'h00};
        send_text();

        // random strings under several limits
        run_random_phase(200, 16'd5, 8);
        wait_drained();
        hold_req = 1'b1;    // output blocked while the input keeps flooding
        run_random_phase(150, 16'd1, 0);
        run_random_phase(150, 16'd2, 4);
        run_random_phase(150, 16'hFFFF, 0);
        run_random_phase(150, 16'hFFFF, 12);
        run_random_phase(200, 16'($urandom_range(0, 20)), 6);
        run_random_phase(200, 16'($urandom_range(0, 65535)), 3);
        run_random_phase(150, 16'hFFFE, 5);
        wait_drained();
        hold_req = 1'b1;
        run_random_phase(200, 16'd3, 2);

        wait_drained();
        if (fail_count == 0)
            $display("[utf8_to_ucs2_decoder] OK");
        else
            $display("[utf8_to_ucs2_decoder] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
src/ucs_pkg.sv
src/ucs_front.sv
src/ucs_fifo.sv
src/ucs_back.sv
src/utf8_to_ucs2_decoder.sv
bench/utf8_to_ucs2_decoder_check.sv
bench/utf8_to_ucs2_decoder_test.sv
